// ===== rtl/core/epg_pkg.sv =====
package epg_pkg;

	localparam int TIME_W = 16;
	localparam int FRAC_BITS = 16;
	localparam int RATE_W = FRAC_BITS + 1;

	localparam int SINE_DEPTH = 256;
	localparam int SINE_IDX_W = $clog2(SINE_DEPTH);
	localparam int SINE_ADDR_W = SINE_IDX_W + 1;
	localparam int POS_W = FRAC_BITS + SINE_IDX_W + 2;

	localparam int DIV_NUM_W = FRAC_BITS + 2;
	localparam int DIV_REM_W = TIME_W;
	localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);

	localparam int MUL_W = FRAC_BITS + 2;
	localparam int PROD_W = 2 * MUL_W;

	// Divide by three as a reciprocal multiply; exact for any MUL_W-bit numerator.
	localparam int THIRD_SHIFT = MUL_W + 1;
	localparam logic [MUL_W-1:0] THIRD_RECIP = MUL_W'(((1 << THIRD_SHIFT) + 2) / 3);

	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;

	localparam logic [RATE_W-1:0] ONE = RATE_W'(1) << FRAC_BITS;
	localparam logic [RATE_W-1:0] HALF = ONE >> 1;
	localparam logic [RATE_W-1:0] BACK_KNEE = RATE_W'((3 * (1 << FRAC_BITS)) / 4);
	localparam logic [RATE_W-1:0] BACK_PEAK = RATE_W'((9 * (1 << FRAC_BITS)) / 8);
	localparam logic [POS_W-1:0] SINE_SPAN = POS_W'(SINE_DEPTH) << FRAC_BITS;

	localparam logic [DIV_CNT_W-1:0] DIV_PROG_STEPS = DIV_CNT_W'(FRAC_BITS);

	localparam logic [63:0] PI_Q30 = 64'd3373259426;

	typedef enum logic [2:0] {
		MODE_LINEAR     = 3'd0,
		MODE_SINE_INOUT = 3'd1,
		MODE_SINE_OUT   = 3'd2,
		MODE_SINE_IN    = 3'd3,
		MODE_QUAD_INOUT = 3'd4,
		MODE_LIN_QUAD   = 3'd5,
		MODE_QUAD_LIN   = 3'd6,
		MODE_BACK       = 3'd7
	} mode_t;

	localparam logic REG_DURATION = 1'b0;
	localparam logic REG_MODE = 1'b1;

	localparam logic OP_STEP = 1'b0;
	localparam logic OP_SET = 1'b1;

	typedef struct packed {
		logic                 start;
		logic [DIV_REM_W-1:0] rem_init;
		logic [DIV_NUM_W-1:0] num;
		logic [DIV_CNT_W-1:0] steps;
		logic [DIV_REM_W-1:0] divisor;
	} div_cmd_t;

	typedef logic [RATE_W-1:0] sine_tab_t [0:SINE_DEPTH];

	// Taylor series of sine in Q2.30, truncating after every product and quotient.
	function automatic logic [63:0] sine_q30(input logic [63:0] x);
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] acc;
		logic [63:0] prod;
		x2 = (x * x) >> 30;
		term = x;
		acc = x;
		for (int k = 1; k <= 10; k++) begin
			prod = (term * x2) >> 30;
			case (k)
				1: term = prod / 6;
				2: term = prod / 20;
				3: term = prod / 42;
				4: term = prod / 72;
				5: term = prod / 110;
				6: term = prod / 156;
				7: term = prod / 210;
				8: term = prod / 272;
				9: term = prod / 342;
				default: term = prod / 420;
			endcase
			if (k % 2 == 1) begin
				acc = (term > acc) ? 64'd0 : acc - term;
			end else begin
				acc = acc + term;
			end
		end
		return acc;
	endfunction

	function automatic sine_tab_t build_sine_tab();
		sine_tab_t tab;
		logic [63:0] x;
		logic [63:0] s;
		logic [63:0] v;
		for (int i = 0; i <= SINE_DEPTH; i++) begin
			x = (PI_Q30 * 64'(i)) / (2 * SINE_DEPTH);
			s = sine_q30(x);
			v = (s + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
			tab[i] = (v > 64'(ONE)) ? ONE : v[RATE_W-1:0];
		end
		return tab;
	endfunction

	localparam sine_tab_t SINE_TAB = build_sine_tab();

endpackage

// ===== rtl/core/eased_progress_generator.sv =====
// Eased progress generator.
// Configuration goes through the APB port: duration_frames at byte address 0,
// easing_mode at byte address 4. Write it only while no item is in flight.
// The req channel carries op and new_time. A step item (op 0) returns the eased
// progress of the current frame counter and then advances the counter while it
// is below duration_frames. A set item (op 1) loads the counter and returns 0.
// Every item returns exactly one item on the rsp channel with the eased rate
// and the counter value after the item.
// A set item goes from acceptance straight to the output stage. A step item
// passes the radix-2 progress divider, which brings it to the curve stage;
// linear then goes on to the output stage, the quadratic curves take one
// multiply, the blend curves one or two (their divide by three is a
// reciprocal multiply on the shared multiplier) and the sine curves two
// table reads and one multiply. With the counter at or past the end there is
// no division and a step item goes straight to the curve stage.
// One item is in work at a time; req_ready is high only while the sequencer
// is idle, so the next item waits until the last one has left the sequencer.
// A finished result sits in the rsp register, so the next item can be taken
// while rsp_ready is low; the block then waits before delivering.
// Reset clears the counter, both registers and rsp_valid.
module eased_progress_generator import epg_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	input  logic                  req_valid,
	output logic                  req_ready,
	input  logic                  op,
	input  logic [TIME_W-1:0]     new_time,
	output logic                  rsp_valid,
	input  logic                  rsp_ready,
	output logic [RATE_W-1:0]     eased_rate,
	output logic [TIME_W-1:0]     time_now
);

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_DIV   = 8'b0000_0010,
		S_EASE  = 8'b0000_0100,
		S_TLO   = 8'b0000_1000,
		S_THI   = 8'b0001_0000,
		S_MUL   = 8'b0010_0000,
		S_THIRD = 8'b0100_0000,
		S_DONE  = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;

	logic [TIME_W-1:0] dur_q;
	mode_t             mode_q;
	logic              reg_idx;
	logic              apb_wr;

	logic [TIME_W-1:0]      cnt_q, cnt_d;
	logic [TIME_W-1:0]      time_q, time_d;
	logic [RATE_W-1:0]      r_q, r_d;
	logic [RATE_W-1:0]      res_q, res_d;
	logic [RATE_W-1:0]      lo_q, lo_d;
	logic [SINE_ADDR_W-1:0] idx_q, idx_d;
	logic [FRAC_BITS-1:0]   frac_q, frac_d;
	logic                   neg_q, neg_d;
	logic                   up_q, up_d;

	logic                  rsp_valid_q;
	logic [RATE_W-1:0]     eased_rate_q;
	logic [TIME_W-1:0]     time_now_q;
	logic                  load_out;

	div_cmd_t               div_cmd;
	logic                   div_done;
	logic [DIV_NUM_W-1:0]   div_quot;
	logic [MUL_W-1:0]       mul_a;
	logic [MUL_W-1:0]       mul_b;
	logic [PROD_W-1:0]      prod;
	logic [SINE_ADDR_W-1:0] rom_addr;
	logic [RATE_W-1:0]      rom_data;

	logic                   at_end;
	logic                   r_low;
	logic [POS_W-1:0]       pos_lin;
	logic [POS_W-1:0]       pos_dbl;
	logic                   dbl_low;
	logic [POS_W-1:0]       pos;
	logic [POS_W-FRAC_BITS-1:0] pos_idx;
	logic                   pos_over;
	logic [SINE_ADDR_W-1:0] pos_addr;
	logic [FRAC_BITS-1:0]   pos_frac;
	logic [SINE_ADDR_W-1:0] hi_addr;
	logic                   hi_ge;
	logic [RATE_W-1:0]      tab_diff;
	logic [RATE_W-1:0]      interp_step;
	logic [RATE_W-1:0]      sine_val;
	logic [RATE_W:0]        inout_sum;
	logic [RATE_W-1:0]      inout_val;
	logic [RATE_W-1:0]      sq_q15;
	logic [MUL_W-1:0]       sq_q14;
	logic [RATE_W-1:0]      third_q;
	logic [RATE_W+1:0]      r_x4;

	// Configuration registers.
	assign reg_idx = paddr[APB_ADDR_W-1];
	assign apb_wr = psel & penable & pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dur_q <= '0;
			mode_q <= MODE_LINEAR;
		end else if (apb_wr) begin
			unique case (reg_idx)
				REG_DURATION: dur_q <= pwdata[TIME_W-1:0];
				REG_MODE:     mode_q <= mode_t'(pwdata[2:0]);
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_DURATION: prdata = APB_DATA_W'(dur_q);
			REG_MODE:     prdata = APB_DATA_W'(mode_q);
		endcase
	end

	// Shared units.
	epg_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (div_cmd),
		.done   (div_done),
		.quot   (div_quot)
	);

	epg_mul u_mul (
		.clk    (clk),
		.a      (mul_a),
		.b      (mul_b),
		.prod_q (prod)
	);

	epg_sine_rom u_rom (
		.clk    (clk),
		.addr   (rom_addr),
		.data_q (rom_data)
	);

	assign at_end = cnt_q >= dur_q;
	assign r_low = r_q < HALF;

	// Table position in steps with FRAC_BITS fraction bits.
	assign pos_lin = POS_W'(r_q) << SINE_IDX_W;
	assign pos_dbl = pos_lin << 1;
	assign dbl_low = pos_dbl <= SINE_SPAN;

	always_comb begin
		unique case (mode_q)
			MODE_SINE_IN:    pos = SINE_SPAN - pos_lin;
			MODE_SINE_INOUT: pos = dbl_low ? SINE_SPAN - pos_dbl : pos_dbl - SINE_SPAN;
			default:         pos = pos_lin;
		endcase
	end

	// Past the last entry the lookup returns that entry; a zero fraction does it.
	assign pos_idx = pos[POS_W-1:FRAC_BITS];
	assign pos_over = pos_idx >= (POS_W - FRAC_BITS)'(SINE_DEPTH);
	assign pos_addr = pos_over ? SINE_ADDR_W'(SINE_DEPTH) : pos_idx[SINE_ADDR_W-1:0];
	assign pos_frac = pos_over ? '0 : pos[FRAC_BITS-1:0];
	assign hi_addr = (idx_q == SINE_ADDR_W'(SINE_DEPTH)) ? idx_q : idx_q + 1'b1;

	assign hi_ge = rom_data >= lo_q;
	assign tab_diff = hi_ge ? rom_data - lo_q : lo_q - rom_data;
	assign interp_step = prod[FRAC_BITS +: RATE_W];
	assign sine_val = up_q ? lo_q + interp_step : lo_q - interp_step;
	assign inout_sum = neg_q ? {1'b0, ONE - sine_val} : {1'b0, ONE} + {1'b0, sine_val};
	assign inout_val = inout_sum[RATE_W:1];

	assign sq_q15 = prod[FRAC_BITS-1 +: RATE_W];
	assign sq_q14 = prod[FRAC_BITS-2 +: MUL_W];
	assign third_q = prod[THIRD_SHIFT +: RATE_W];
	assign r_x4 = {r_q, 2'b00};

	always_comb begin
		state_d = state_q;
		cnt_d = cnt_q;
		time_d = time_q;
		r_d = r_q;
		res_d = res_q;
		lo_d = lo_q;
		idx_d = idx_q;
		frac_d = frac_q;
		neg_d = neg_q;
		up_d = up_q;
		div_cmd = '0;
		mul_a = '0;
		mul_b = '0;
		rom_addr = idx_q;
		load_out = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					if (op == OP_SET) begin
						cnt_d = new_time;
						time_d = new_time;
						res_d = '0;
						state_d = S_DONE;
					end else begin
						cnt_d = at_end ? cnt_q : cnt_q + 1'b1;
						time_d = cnt_d;
						if (at_end) begin
							r_d = ONE;
							state_d = S_EASE;
						end else begin
							div_cmd.start = 1'b1;
							div_cmd.rem_init = cnt_q;
							div_cmd.num = '0;
							div_cmd.steps = DIV_PROG_STEPS;
							div_cmd.divisor = dur_q;
							state_d = S_DIV;
						end
					end
				end
			end
			S_DIV: begin
				if (div_done) begin
					r_d = div_quot[RATE_W-1:0];
					state_d = S_EASE;
				end
			end
			S_EASE: begin
				unique case (mode_q)
					MODE_LINEAR: begin
						res_d = r_q;
						state_d = S_DONE;
					end
					MODE_QUAD_INOUT: begin
						mul_a = MUL_W'(r_low ? r_q : ONE - r_q);
						mul_b = mul_a;
						state_d = S_MUL;
					end
					MODE_BACK: begin
						mul_a = MUL_W'((r_q > BACK_KNEE) ? r_q - BACK_KNEE : BACK_KNEE - r_q);
						mul_b = mul_a;
						state_d = S_MUL;
					end
					MODE_LIN_QUAD: begin
						if (r_low) begin
							mul_a = MUL_W'(r_x4);
							mul_b = THIRD_RECIP;
							state_d = S_THIRD;
						end else begin
							mul_a = MUL_W'(ONE - r_q);
							mul_b = mul_a;
							state_d = S_MUL;
						end
					end
					MODE_QUAD_LIN: begin
						if (r_low) begin
							mul_a = MUL_W'(r_q);
							mul_b = MUL_W'(r_q);
							state_d = S_MUL;
						end else begin
							mul_a = MUL_W'(r_x4 - {2'b00, ONE});
							mul_b = THIRD_RECIP;
							state_d = S_THIRD;
						end
					end
					MODE_SINE_INOUT, MODE_SINE_OUT, MODE_SINE_IN: begin
						rom_addr = pos_addr;
						idx_d = pos_addr;
						frac_d = pos_frac;
						neg_d = dbl_low;
						state_d = S_TLO;
					end
				endcase
			end
			S_TLO: begin
				rom_addr = hi_addr;
				lo_d = rom_data;
				state_d = S_THI;
			end
			S_THI: begin
				up_d = hi_ge;
				mul_a = MUL_W'(tab_diff);
				mul_b = MUL_W'(frac_q);
				state_d = S_MUL;
			end
			S_MUL: begin
				state_d = S_DONE;
				unique case (mode_q)
					MODE_QUAD_INOUT: res_d = r_low ? sq_q15 : ONE - sq_q15;
					MODE_BACK:       res_d = BACK_PEAK - sq_q15;
					MODE_LIN_QUAD, MODE_QUAD_LIN: begin
						mul_a = sq_q14;
						mul_b = THIRD_RECIP;
						state_d = S_THIRD;
					end
					MODE_SINE_OUT:   res_d = sine_val;
					MODE_SINE_IN:    res_d = ONE - sine_val;
					MODE_SINE_INOUT: res_d = inout_val;
					MODE_LINEAR:     res_d = r_q;
				endcase
			end
			S_THIRD: begin
				res_d = (mode_q == MODE_LIN_QUAD && !r_low) ? ONE - third_q : third_q;
				state_d = S_DONE;
			end
			S_DONE: begin
				if (!rsp_valid_q || rsp_ready) begin
					load_out = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q <= cnt_d;
			if (load_out) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		time_q <= time_d;
		r_q <= r_d;
		res_q <= res_d;
		lo_q <= lo_d;
		idx_q <= idx_d;
		frac_q <= frac_d;
		neg_q <= neg_d;
		up_q <= up_d;
		if (load_out) begin
			eased_rate_q <= res_q;
			time_now_q <= time_q;
		end
	end

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign eased_rate = eased_rate_q;
	assign time_now = time_now_q;

endmodule

// ===== rtl/core/epg_div.sv =====
module epg_div import epg_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  div_cmd_t             cmd,
	output logic                 done,
	output logic [DIV_NUM_W-1:0] quot
);

	logic [DIV_REM_W-1:0] rem_q;
	logic [DIV_REM_W-1:0] dvs_q;
	logic [DIV_NUM_W-1:0] qn_q;
	logic [DIV_CNT_W-1:0] left_q;
	logic                 busy_q;
	logic                 done_q;

	logic [DIV_REM_W:0] trial;
	logic [DIV_REM_W:0] diff;
	logic               take;

	// One quotient bit per cycle: numerator bits leave the top of qn_q as
	// quotient bits enter at the bottom.
	assign trial = {rem_q, qn_q[DIV_NUM_W-1]};
	assign take = trial >= {1'b0, dvs_q};
	assign diff = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			left_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				busy_q <= 1'b1;
				left_q <= cmd.steps;
			end else if (busy_q) begin
				left_q <= left_q - 1'b1;
				if (left_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			rem_q <= cmd.rem_init;
			qn_q <= cmd.num;
			dvs_q <= cmd.divisor;
		end else if (busy_q) begin
			rem_q <= take ? diff[DIV_REM_W-1:0] : trial[DIV_REM_W-1:0];
			qn_q <= {qn_q[DIV_NUM_W-2:0], take};
		end
	end

	assign done = done_q;
	assign quot = qn_q;

endmodule

// ===== rtl/core/epg_mul.sv =====
module epg_mul import epg_pkg::*; (
	input  logic              clk,
	input  logic [MUL_W-1:0]  a,
	input  logic [MUL_W-1:0]  b,
	output logic [PROD_W-1:0] prod_q
);

	always_ff @(posedge clk) begin
		prod_q <= PROD_W'(a) * PROD_W'(b);
	end

endmodule

// ===== rtl/core/epg_sine_rom.sv =====
module epg_sine_rom import epg_pkg::*; (
	input  logic                   clk,
	input  logic [SINE_ADDR_W-1:0] addr,
	output logic [RATE_W-1:0]      data_q
);

	always_ff @(posedge clk) begin
		data_q <= SINE_TAB[addr];
	end

endmodule

// ===== verif/epg_checker.sv =====
module epg_checker import epg_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	input  logic [APB_DATA_W-1:0] prdata,
	input  logic                  pready,
	input  logic                  req_valid,
	input  logic                  req_ready,
	input  logic                  op,
	input  logic [TIME_W-1:0]     new_time,
	input  logic                  rsp_valid,
	input  logic                  rsp_ready,
	input  logic [RATE_W-1:0]     eased_rate,
	input  logic [TIME_W-1:0]     time_now,
	output int                    mismatches,
	output int                    checked,
	output int                    outstanding
);

	localparam int FRAC = 16;
	localparam int QDEPTH = 256;
	localparam int QIDX_W = $clog2(QDEPTH + 1);
	localparam logic [63:0] UNIT = 64'd1 << FRAC;
	localparam logic [63:0] HALF_UNIT = UNIT >> 1;
	localparam logic [63:0] SPAN = 64'(QDEPTH) << FRAC;
	localparam logic [63:0] PI_30 = 64'd3373259426;

	typedef struct packed {
		logic [RATE_W-1:0] rate;
		logic [TIME_W-1:0] count;
	} frame_result_t;

	logic [63:0] quarter_wave [0:QDEPTH];
	frame_result_t due_results [$];
	frame_result_t want;
	frame_result_t got;
	logic [TIME_W-1:0] cfg_duration;
	mode_t cfg_mode;
	logic [TIME_W-1:0] frame_count;
	logic [63:0] progress;
	logic [APB_DATA_W-1:0] reg_value;

	// Sine in Q2.30 from eleven terms of its series, truncating every product and quotient.
	function automatic logic [63:0] taylor_sine(logic [63:0] x);
		logic [63:0] x_sq;
		logic [63:0] term;
		logic [63:0] acc;
		x_sq = (x * x) >> 30;
		term = x;
		acc = x;
		for (int k = 1; k <= 10; k++) begin
			term = ((term * x_sq) >> 30) / (64'(2 * k) * 64'(2 * k + 1));
			if (k % 2 == 1)
				acc = (term > acc) ? 64'd0 : acc - term;
			else
				acc = acc + term;
		end
		return acc;
	endfunction

	initial begin : fill_wave
		logic [63:0] angle;
		logic [63:0] rounded;
		for (int i = 0; i <= QDEPTH; i++) begin
			angle = (PI_30 * 64'(i)) / 64'(2 * QDEPTH);
			rounded = (taylor_sine(angle) + (64'd1 << (29 - FRAC))) >> (30 - FRAC);
			quarter_wave[i] = (rounded > UNIT) ? UNIT : rounded;
		end
	end

	// Position is in table steps with FRAC fraction bits.
	function automatic logic [63:0] wave_at(logic [63:0] pos);
		logic [63:0] idx;
		logic [63:0] frac;
		logic [63:0] lo;
		logic [63:0] hi;
		idx = pos >> FRAC;
		frac = pos & (UNIT - 1);
		if (idx >= QDEPTH)
			return quarter_wave[QDEPTH];
		lo = quarter_wave[idx[QIDX_W-1:0]];
		hi = quarter_wave[idx[QIDX_W-1:0] + QIDX_W'(1)];
		if (hi >= lo)
			return lo + (((hi - lo) * frac) >> FRAC);
		return lo - (((lo - hi) * frac) >> FRAC);
	endfunction

	function automatic logic [63:0] shape_progress(mode_t mode, logic [63:0] r);
		logic [63:0] d;
		logic [63:0] p;
		case (mode)
			MODE_SINE_INOUT: begin
				p = 2 * r * QDEPTH;
				if (p <= SPAN)
					return (UNIT - wave_at(SPAN - p)) >> 1;
				return (UNIT + wave_at(p - SPAN)) >> 1;
			end
			MODE_SINE_OUT: return wave_at(r * QDEPTH);
			MODE_SINE_IN: return UNIT - wave_at(SPAN - r * QDEPTH);
			MODE_QUAD_INOUT: begin
				if (r < HALF_UNIT)
					return (2 * r * r) >> FRAC;
				d = UNIT - r;
				return UNIT - ((2 * d * d) >> FRAC);
			end
			MODE_LIN_QUAD: begin
				if (r < HALF_UNIT)
					return (4 * r) / 3;
				d = UNIT - r;
				return UNIT - (4 * d * d) / (3 * UNIT);
			end
			MODE_QUAD_LIN: begin
				if (r < HALF_UNIT)
					return (4 * r * r) / (3 * UNIT);
				return (4 * r - UNIT) / 3;
			end
			MODE_BACK: begin
				p = (3 * UNIT) >> 2;
				d = (r > p) ? r - p : p - r;
				return ((9 * UNIT) >> 3) - ((2 * d * d) >> FRAC);
			end
			default: return r;
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_duration = '0;
			cfg_mode = MODE_LINEAR;
			frame_count = '0;
			due_results.delete();
			mismatches = 0;
			checked = 0;
			outstanding = 0;
		end else begin
			if (psel && penable && pready) begin
				if (pwrite) begin
					if (paddr[APB_ADDR_W-1] == REG_MODE)
						cfg_mode = mode_t'(pwdata[2:0]);
					else
						cfg_duration = pwdata[TIME_W-1:0];
				end else begin
					reg_value = (paddr[APB_ADDR_W-1] == REG_MODE) ? APB_DATA_W'(cfg_mode)
						: APB_DATA_W'(cfg_duration);
					if (prdata !== reg_value) begin
						$error("prdata mismatch at address %0d: expected %0d, actual %0d",
							paddr, reg_value, prdata);
						mismatches++;
					end
				end
			end

			if (req_valid && req_ready) begin
				if (op == OP_SET) begin
					frame_count = new_time;
					want.rate = '0;
				end else begin
					if (cfg_duration == 0 || frame_count >= cfg_duration)
						progress = UNIT;
					else
						progress = (64'(frame_count) << FRAC) / 64'(cfg_duration);
					want.rate = RATE_W'(shape_progress(cfg_mode, progress));
					if (frame_count < cfg_duration)
						frame_count = frame_count + 1'b1;
				end
				want.count = frame_count;
				due_results.push_back(want);
			end

			if (rsp_valid && rsp_ready) begin
				if (due_results.size() == 0) begin
					$error("result arrived with no item outstanding: eased_rate %0d, time_now %0d",
						eased_rate, time_now);
					mismatches++;
				end else begin
					got = due_results.pop_front();
					checked++;
					if (eased_rate !== got.rate) begin
						$error("eased_rate mismatch: expected %0d, actual %0d", got.rate, eased_rate);
						mismatches++;
					end
					if (time_now !== got.count) begin
						$error("time_now mismatch: expected %0d, actual %0d", got.count, time_now);
						mismatches++;
					end
				end
			end

			outstanding = due_results.size();
		end
	end

endmodule

// ===== verif/tb.sv =====
module tb;
	import epg_pkg::*;

	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int RANDOM_ITEMS = 1500;
	localparam int LONG_HOLD = 400;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [APB_ADDR_W-1:0] paddr = '0;
	logic [APB_DATA_W-1:0] pwdata = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic pready;
	logic req_valid = 1'b0;
	logic req_ready;
	logic op = OP_STEP;
	logic [TIME_W-1:0] new_time = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	logic [RATE_W-1:0] eased_rate;
	logic [TIME_W-1:0] time_now;

	int mismatches;
	int checked;
	int outstanding;
	logic req_fire = 1'b0;
	bit sender_calm = 1'b0;
	int items_sent = 0;
	int loads_sent = 0;
	int settings_used = 0;

	eased_progress_generator dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
		.prdata(prdata), .pready(pready),
		.req_valid(req_valid), .req_ready(req_ready), .op(op), .new_time(new_time),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .eased_rate(eased_rate),
		.time_now(time_now)
	);

	epg_checker chk (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
		.prdata(prdata), .pready(pready),
		.req_valid(req_valid), .req_ready(req_ready), .op(op), .new_time(new_time),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .eased_rate(eased_rate),
		.time_now(time_now),
		.mismatches(mismatches), .checked(checked), .outstanding(outstanding)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Seen at the falling edge, this tells whether the last rising edge took an item.
	always @(posedge clk) begin
		req_fire <= req_valid && req_ready;
	end

	function automatic int pick_gap(bit calm);
		int roll;
		if (calm)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		if (roll < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic reg_access(logic wr, logic idx, logic [APB_DATA_W-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		while (outstanding != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// Upper bits of each write carry noise, which the register must drop.
	task automatic set_curve(logic [TIME_W-1:0] duration, mode_t mode);
		logic [APB_DATA_W-1:0] noise;
		wait_drained();
		noise = $urandom;
		reg_access(1'b1, REG_DURATION, {noise[APB_DATA_W-1:TIME_W], duration});
		reg_access(1'b0, REG_DURATION, '0);
		noise = $urandom;
		reg_access(1'b1, REG_MODE, {noise[APB_DATA_W-1:3], mode});
		reg_access(1'b0, REG_MODE, '0);
		settings_used++;
	endtask

	task automatic send_item(logic kind, logic [TIME_W-1:0] value);
		int gap;
		req_valid <= 1'b1;
		op <= kind;
		new_time <= value;
		do
			@(negedge clk);
		while (!req_fire);
		items_sent++;
		if (kind == OP_SET)
			loads_sent++;
		gap = pick_gap(sender_calm);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	task automatic end_burst();
		req_valid <= 1'b0;
		@(negedge clk);
	endtask

	initial begin : drain
		int stall_left;
		bit calm;
		bit held_long;
		stall_left = 0;
		calm = 1'b0;
		held_long = 1'b0;
		forever begin
			@(negedge clk);
			if ($urandom_range(0, 199) == 0)
				calm = !calm;
			// One long hold while the sender is still offering, so the block backs up.
			if (!held_long && checked >= 60 && req_valid) begin
				held_long = 1'b1;
				rsp_ready <= 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
			end else if (stall_left > 0) begin
				rsp_ready <= 1'b0;
				stall_left--;
			end else begin
				rsp_ready <= 1'b1;
				stall_left = pick_gap(calm);
			end
		end
	end

	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("tb failed");
		$finish;
	end

	initial begin : stimulus
		int random_items;
		int phase;
		int count;
		int span_end;
		logic [TIME_W-1:0] duration;
		logic [TIME_W-1:0] load;
		random_items = 0;
		phase = 0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Zero duration: progress is one, loads still land in the counter.
		set_curve('0, MODE_LINEAR);
		send_item(OP_STEP, TIME_W'($urandom));
		send_item(OP_SET, '1);
		send_item(OP_STEP, TIME_W'($urandom));
		send_item(OP_SET, '0);
		send_item(OP_STEP, TIME_W'($urandom));
		end_burst();

		// Longest duration, counter walking up to it, then the overshoot peak.
		set_curve('1, MODE_BACK);
		send_item(OP_SET, 16'hFFFE);
		send_item(OP_STEP, TIME_W'($urandom));
		send_item(OP_STEP, TIME_W'($urandom));
		send_item(OP_STEP, TIME_W'($urandom));
		send_item(OP_SET, '0);
		send_item(OP_STEP, TIME_W'($urandom));
		send_item(OP_SET, 16'hC000);
		send_item(OP_STEP, TIME_W'($urandom));
		end_burst();

		// Counter loaded past the end of a short curve, then a full sweep.
		set_curve(16'd4, MODE_SINE_INOUT);
		send_item(OP_SET, 16'd10);
		send_item(OP_STEP, TIME_W'($urandom));
		send_item(OP_SET, '0);
		repeat (5) send_item(OP_STEP, TIME_W'($urandom));
		end_burst();

		while (random_items < RANDOM_ITEMS) begin
			case ($urandom_range(0, 9))
				0: duration = '0;
				1: duration = '1;
				2, 3: duration = TIME_W'($urandom);
				default: duration = TIME_W'($urandom_range(1, 48));
			endcase
			set_curve(duration, mode_t'(phase % 8));
			sender_calm = ($urandom_range(0, 3) == 0);
			count = $urandom_range(20, 60);
			for (int i = 0; i < count; i++) begin
				if ($urandom_range(0, 5) == 0) begin
					span_end = int'(duration) + 1;
					if ($urandom_range(0, 2) == 0)
						load = TIME_W'($urandom);
					else
						load = TIME_W'($urandom_range(0, span_end));
					send_item(OP_SET, load);
				end else begin
					send_item(OP_STEP, TIME_W'($urandom));
				end
				random_items++;
			end
			end_burst();
			phase++;
		end

		while (outstanding != 0)
			@(negedge clk);
		repeat (60) @(negedge clk);

		$display("Sent %0d items (%0d counter loads) over %0d register settings on all eight curves,",
			items_sent, loads_sent, settings_used);
		$display("with random stalls and one long output hold; %0d results compared.", checked);
		if (mismatches == 0) begin
			$display("tb passed");
		end else begin
			$display("tb failed");
		end
		$finish;
	end

endmodule
